// File: hdl/ptok_pkg.sv
// Shared types and constants for the plotter command tokenizer.
package ptok_pkg;

    localparam int MAX_ARGS_DEFAULT = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [15:0] ARG_MAX_VALUE = 16'hFFFF;

    // Result kinds as they appear on the output channel.
    localparam logic [1:0] KIND_ARG = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_ARGS
    } phase_t;

    // Everything one input byte produces: an optional argument result
    // followed by an optional end or error result.
    typedef struct packed {
        logic        has_arg;
        logic [1:0]  arg_kind;
        logic [3:0]  arg_idx;
        logic [15:0] arg_value;
        logic        has_tail;
        logic [1:0]  tail_kind;
        logic [3:0]  tail_idx;
        logic [4:0]  total;
        logic [7:0]  first;
        logic [7:0]  second;
    } job_t;

endpackage

// File: hdl/ptok_if.sv
// Channel interfaces: received bytes in, tokens out.
interface ptok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ptok_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  mnemonic_first;
    logic [7:0]  mnemonic_second;
    logic [3:0]  arg_index;
    logic [15:0] arg_value;
    logic [4:0]  arg_total;
    logic        last_of_run;

    modport source (output valid, output kind, output mnemonic_first,
                    output mnemonic_second, output arg_index, output arg_value,
                    output arg_total, output last_of_run, input ready);
    modport sink   (input valid, input kind, input mnemonic_first,
                    input mnemonic_second, input arg_index, input arg_value,
                    input arg_total, input last_of_run, output ready);
endinterface

// File: hdl/ptok_front.sv
// Front end: classifies each byte, tracks the command state, builds jobs.
module ptok_front #(
    parameter int MAX_ARGS = ptok_pkg::MAX_ARGS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    ptok_byte_if.sink          char_ch,
    input  logic               q_full,
    output logic               job_valid,
    output ptok_pkg::job_t     job
);
    import ptok_pkg::*;

    localparam int CW = $clog2(MAX_ARGS + 1);

    phase_t          phase_reg, phase_next;
    logic [7:0]      first_reg, first_next;
    logic [7:0]      second_reg, second_next;
    logic [15:0]     acc_reg, acc_next;
    logic            innum_reg, innum_next;
    logic [CW-1:0]   count_reg, count_next;

    logic            accept;
    logic [7:0]      b;
    logic            is_digit;
    logic            is_space;
    logic [20:0]     acc_mul;
    logic [31:0]     count_ext;
    logic [31:0]     count_next_ext;
    logic            has_arg;
    logic [1:0]      arg_kind;
    logic            has_tail;
    logic [1:0]      tail_kind;
    logic            tail_is_err;

    assign char_ch.ready = !q_full;
    assign accept        = char_ch.valid && char_ch.ready;
    assign b             = char_ch.in_byte;
    assign is_digit      = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_space      = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    // acc * 10 + digit, as acc*8 + acc*2 + digit.
    assign acc_mul       = {2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0}
                         + {17'd0, b[3:0] - CH_ZERO[3:0]};
    assign count_ext      = 32'(count_reg);
    assign count_next_ext = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        count_next  = count_reg;
        has_arg     = 1'b0;
        arg_kind    = KIND_ARG;
        has_tail    = 1'b0;
        tail_kind   = KIND_END;
        tail_is_err = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (!is_space)
                    begin
                        first_next  = b;
                        second_next = '0;
                        acc_next    = '0;
                        innum_next  = 1'b0;
                        count_next  = '0;
                        phase_next  = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    second_next = b;
                    phase_next  = PH_ARGS;
                end
                PH_ARGS:
                begin
                    if (is_digit)
                    begin
                        acc_next   = (acc_mul > 21'(ARG_MAX_VALUE)) ? ARG_MAX_VALUE
                                                                   : acc_mul[15:0];
                        innum_next = 1'b1;
                    end
                    else
                    begin
                        // Any non-digit closes a pending number first.
                        if (innum_reg)
                        begin
                            has_arg    = 1'b1;
                            innum_next = 1'b0;
                            acc_next   = '0;
                            if (count_reg < CW'(MAX_ARGS))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                arg_kind = KIND_ERR;
                            end
                        end
                        if (b == CH_SEMI)
                        begin
                            has_tail   = 1'b1;
                            tail_kind  = KIND_END;
                            phase_next = PH_FIRST;
                        end
                        else if (!is_space && (b != CH_COMMA))
                        begin
                            has_tail    = 1'b1;
                            tail_kind   = KIND_ERR;
                            tail_is_err = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    assign job_valid = has_arg || has_tail;

    always_comb
    begin
        job.has_arg   = has_arg;
        job.arg_kind  = arg_kind;
        job.arg_idx   = count_ext[3:0];
        job.arg_value = acc_reg;
        job.has_tail  = has_tail;
        job.tail_kind = tail_kind;
        job.tail_idx  = tail_is_err ? count_next_ext[3:0] : 4'd0;
        job.total     = count_next_ext[4:0];
        job.first     = first_reg;
        job.second    = second_reg;
    end

endmodule

// File: hdl/ptok_queue.sv
// Small job queue between the front end and the result sequencer.
module ptok_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptok_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output ptok_pkg::job_t head_job
);
    import ptok_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/ptok_back.sv
// Back end: expands each job into one or two token beats on the output register.
module ptok_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  ptok_pkg::job_t head_job,
    output logic           pop,
    ptok_token_if.source   token_ch
);
    import ptok_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        tail_pend_reg, tail_pend_next;
    job_t        held_reg, held_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] value_reg, value_next;
    logic [4:0]  total_reg, total_next;
    logic        last_reg, last_next;
    logic        can_load;

    assign can_load = !out_valid_reg || token_ch.ready;
    assign pop      = can_load && !tail_pend_reg && head_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        tail_pend_next = tail_pend_reg;
        held_next      = held_reg;
        kind_next      = kind_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        if (can_load)
        begin
            priority if (tail_pend_reg)
            begin
                out_valid_next = 1'b1;
                tail_pend_next = 1'b0;
                kind_next      = held_reg.tail_kind;
                first_next     = held_reg.first;
                second_next    = held_reg.second;
                idx_next       = held_reg.tail_idx;
                value_next     = '0;
                total_next     = held_reg.total;
                last_next      = 1'b1;
            end
            else if (head_valid)
            begin
                out_valid_next = 1'b1;
                first_next     = head_job.first;
                second_next    = head_job.second;
                total_next     = head_job.total;
                if (head_job.has_arg)
                begin
                    kind_next      = head_job.arg_kind;
                    idx_next       = head_job.arg_idx;
                    value_next     = head_job.arg_value;
                    last_next      = !head_job.has_tail;
                    tail_pend_next = head_job.has_tail;
                    held_next      = head_job;
                end
                else
                begin
                    kind_next  = head_job.tail_kind;
                    idx_next   = head_job.tail_idx;
                    value_next = '0;
                    last_next  = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tail_pend_reg <= tail_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg   <= held_next;
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        total_reg  <= total_next;
        last_reg   <= last_next;
    end

    assign token_ch.valid           = out_valid_reg;
    assign token_ch.kind            = kind_reg;
    assign token_ch.mnemonic_first  = first_reg;
    assign token_ch.mnemonic_second = second_reg;
    assign token_ch.arg_index       = idx_reg;
    assign token_ch.arg_value       = value_reg;
    assign token_ch.arg_total       = total_reg;
    assign token_ch.last_of_run     = last_reg;

`ifndef SYNTHESIS
    // A second result is only ever queued behind a beat already on the output.
    a_tail_behind_beat: assert property (@(posedge clk) disable iff (!rst_n)
        tail_pend_reg |-> out_valid_reg)
        else $error("tail pending without an output beat");

    // The first of a pair is an argument result, never an end of command.
    a_pair_head_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tail_pend_reg |-> (kind_reg != KIND_END))
        else $error("end of command beat ahead of a pending tail");

    // A beat that is not the last of its byte always has its partner waiting.
    a_not_last_has_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> tail_pend_reg)
        else $error("non-final beat with no pending tail");

    // No new job is taken while the second half of a pair is outstanding.
    a_no_pop_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        tail_pend_reg |-> !pop)
        else $error("queue popped during a result pair");
`endif

endmodule

// File: hdl/plotter_command_tokenizer.sv
// Plotter command tokenizer top level: byte channel in, token channel out.
//
// The char_ch channel takes one received ASCII byte per beat. A command is two
// mnemonic bytes, comma-separated unsigned decimal arguments and a closing
// semicolon; whitespace is skipped. The token_ch channel gives one beat per
// result: a completed argument, an end of command, or an error for a dropped
// byte or an argument beyond MAX_ARGS. last_of_run marks the final beat that
// a byte causes.
// A byte is accepted every cycle while the four-entry job queue has room. The
// first result of a byte passes through the job queue and the output register
// before it is valid on token_ch. A byte that yields two results holds the
// output register for both beats, so a sustained stream of such bytes is
// limited by the single output register.
// When the receiver stalls, the output beat holds and the queue absorbs up to
// four jobs before char_ch.ready drops. Reset clears the command state, the
// queue and the output valid flag; the block waits for a first mnemonic byte.
module plotter_command_tokenizer #(
    parameter int MAX_ARGS = ptok_pkg::MAX_ARGS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ptok_byte_if.sink    char_ch,
    ptok_token_if.source token_ch
);
    import ptok_pkg::*;

    logic job_valid;
    job_t job;
    logic q_full;
    logic q_pop;
    logic head_valid;
    job_t head_job;

    ptok_front #(
        .MAX_ARGS (MAX_ARGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .q_full    (q_full),
        .job_valid (job_valid),
        .job       (job)
    );

    ptok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    ptok_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .token_ch   (token_ch)
    );

endmodule

// File: tb/ptok_checker.sv
// Scoreboard for the plotter command tokenizer: predicts the tokens and checks each beat.
module ptok_checker #(
    parameter int MAX_ARGS = ptok_pkg::MAX_ARGS_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    ptok_byte_if  bytes,
    ptok_token_if tokens,
    output int    mismatches,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptok_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [3:0]  index;
        logic [15:0] value;
        logic [4:0]  total;
        logic        last;
    } token_t;

    token_t expected_tokens[$];
    token_t staged[$];

    // Command state as the tokenizer should hold it.
    phase_t      phase;
    logic [7:0]  cmd_first;
    logic [7:0]  cmd_second;
    logic [15:0] accum;
    logic        in_number;
    int          arg_count;

    int bytes_seen;
    int arg_beats;
    int end_beats;
    int err_beats;

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    task automatic report(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    task automatic stage(logic [1:0] kind, logic [3:0] index, logic [15:0] value);
        staged.push_back(token_t'{kind: kind, first: cmd_first, second: cmd_second,
                                  index: index, value: value, total: 5'(arg_count),
                                  last: 1'b0});
    endtask

    // A number ends: it becomes an argument, or an error once the count is full.
    task automatic close_number();
        int idx;
        if (in_number) begin
            in_number = 1'b0;
            idx = arg_count;
            if (arg_count < MAX_ARGS) begin
                arg_count++;
                stage(KIND_ARG, 4'(idx), accum);
            end
            else begin
                stage(KIND_ERR, 4'(idx), accum);
            end
            accum = '0;
        end
    endtask

    task automatic predict_tokens(logic [7:0] b);
        int v;
        staged.delete();
        case (phase)
            PH_FIRST:
                if (!is_blank(b)) begin
                    cmd_first  = b;
                    cmd_second = '0;
                    accum      = '0;
                    in_number  = 1'b0;
                    arg_count  = 0;
                    phase      = PH_SECOND;
                end
            PH_SECOND:
                begin
                    cmd_second = b;
                    phase      = PH_ARGS;
                end
            default:
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    v = int'(accum) * 10 + int'(b - CH_ZERO);
                    accum = (v > 65535) ? ARG_MAX_VALUE : 16'(v);
                    in_number = 1'b1;
                end
                else if (is_blank(b) || b == CH_COMMA) begin
                    close_number();
                end
                else if (b == CH_SEMI) begin
                    close_number();
                    stage(KIND_END, 4'd0, 16'd0);
                    phase = PH_FIRST;
                end
                else begin
                    close_number();
                    stage(KIND_ERR, 4'(arg_count), 16'd0);
                end
        endcase
        if (staged.size() > 0)
            staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i])
            expected_tokens.push_back(staged[i]);
    endtask

    task automatic compare_token();
        token_t want;
        case (tokens.kind)
            KIND_ARG: arg_beats++;
            KIND_END: end_beats++;
            default:  err_beats++;
        endcase
        if (expected_tokens.size() == 0) begin
            report($sformatf("token beat of kind %0d with nothing expected", tokens.kind));
        end
        else begin
            want = expected_tokens.pop_front();
            check_field("kind", want.kind, tokens.kind);
            check_field("mnemonic_first", want.first, tokens.mnemonic_first);
            check_field("mnemonic_second", want.second, tokens.mnemonic_second);
            check_field("arg_index", want.index, tokens.arg_index);
            check_field("arg_value", want.value, tokens.arg_value);
            check_field("arg_total", want.total, tokens.arg_total);
            check_field("last_of_run", want.last, tokens.last_of_run);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase      <= PH_FIRST;
            cmd_first  <= '0;
            cmd_second <= '0;
            accum      <= '0;
            in_number  <= 1'b0;
            arg_count  <= 0;
            expected_tokens.delete();
            pending    <= 0;
        end
        else begin
            if (bytes.valid && bytes.ready) begin
                bytes_seen++;
                predict_tokens(bytes.in_byte);
            end
            if (tokens.valid && tokens.ready)
                compare_token();
            pending <= expected_tokens.size();
        end
    end

    // Called once the stream has drained: whatever is still queued never arrived.
    task automatic final_check();
        while (expected_tokens.size() > 0) begin
            report($sformatf("expected token of kind %0d never arrived",
                             expected_tokens[0].kind));
            void'(expected_tokens.pop_front());
        end
        $display("Covered %0d bytes giving %0d argument, %0d end-of-command and %0d error beats.",
                 bytes_seen, arg_beats, end_beats, err_beats);
        $display("Streams included saturated values, overfull commands, junk and noise bytes.");
    endtask

endmodule

// File: tb/tb.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus, token back-pressure, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptok_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int mismatches;
    int pending;

    ptok_byte_if  byte_ch ();
    ptok_token_if tok_ch ();

    plotter_command_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (byte_ch),
        .token_ch (tok_ch)
    );

    ptok_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (byte_ch),
        .tokens     (tok_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        tok_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send(logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send(s[i]);
    endtask

    task automatic send_blanks(int n);
        logic [7:0] pick[4];
        pick = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        repeat (n)
            send(pick[$urandom_range(0, 3)]);
    endtask

    function automatic logic [7:0] letter();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    // A byte that is neither digit, blank, comma nor semicolon.
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COMMA || b == CH_SEMI ||
               b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_number();
        int ndig;
        ndig = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (ndig)
            send(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_command();
        int nargs;
        if ($urandom_range(0, 3) == 0)
            send_blanks($urandom_range(1, 3));
        send(($urandom_range(0, 99) < 85) ? letter() : 8'($urandom_range(0, 255)));
        send(($urandom_range(0, 99) < 85) ? letter() : 8'($urandom_range(0, 255)));
        nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 5);
        for (int i = 0; i < nargs; i++) begin
            if (i > 0) begin
                case ($urandom_range(0, 5))
                    3: send_blanks($urandom_range(1, 2));
                    4:
                        begin
                            send_blanks(1);
                            send(CH_COMMA);
                            send_blanks(1);
                        end
                    5:
                        begin
                            send(CH_COMMA);
                            send(CH_COMMA);
                        end
                    default: send(CH_COMMA);
                endcase
            end
            send_number();
            if ($urandom_range(0, 14) == 0)
                send(junk_byte());
        end
        // Most commands close properly; the rest run into the next one.
        if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 4) == 0)
                send_blanks(1);
            send(CH_SEMI);
        end
    endtask

    task automatic random_stream(int budget);
        int target;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 4))
                    send(8'($urandom_range(0, 255)));
            end
            else begin
                send_command();
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        tok_ch.ready    = 1'b0;
        bytes_sent      = 0;
        idle_pct        = 32;
        stall_pct       = 87;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, a blank as second mnemonic byte, saturation, empty
        // arguments and a dropped byte after a pending number.
        send_text(" PA0,65535;");
        send_text("X\t99999,,;");
        send_text("CD7!;");

        random_stream(250);
        idle_pct  = 87;
        stall_pct = 32;
        random_stream(250);
        idle_pct  = 0;
        stall_pct = 0;
        random_stream(250);
        byte_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        chk.final_check();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400us;
        $display("Mismatches found");
        $finish;
    end

endmodule
